// ===== rtl/uvdc_pkg.sv =====
// Shared widths and constants of the UTF-8 validate, decode and count block.
package uvdc_pkg;

    localparam int UVDC_COUNT_BITS = 16;
    localparam int UVDC_CP_W       = 21;
    localparam int UVDC_CNT_W      = 16;
    localparam int UVDC_LEN_W      = 3;
    localparam int UVDC_PEND_W     = 2;

    // Start byte ranges
    localparam logic [7:0] UVDC_B2_LO = 8'hC2;
    localparam logic [7:0] UVDC_B2_HI = 8'hDF;
    localparam logic [7:0] UVDC_B3_LO = 8'hE0;
    localparam logic [7:0] UVDC_B3_HI = 8'hEF;
    localparam logic [7:0] UVDC_B4_LO = 8'hF0;
    localparam logic [7:0] UVDC_B4_HI = 8'hF4;

    // Sequence lengths
    localparam logic [UVDC_LEN_W-1:0] UVDC_LEN_NONE = 3'd0;
    localparam logic [UVDC_LEN_W-1:0] UVDC_LEN_2    = 3'd2;
    localparam logic [UVDC_LEN_W-1:0] UVDC_LEN_3    = 3'd3;
    localparam logic [UVDC_LEN_W-1:0] UVDC_LEN_4    = 3'd4;

    // Scalar value limits
    localparam logic [UVDC_CP_W-1:0] UVDC_MIN_3   = 21'h000800;
    localparam logic [UVDC_CP_W-1:0] UVDC_MIN_4   = 21'h010000;
    localparam logic [UVDC_CP_W-1:0] UVDC_SURR_LO = 21'h00D800;
    localparam logic [UVDC_CP_W-1:0] UVDC_SURR_HI = 21'h00DFFF;
    localparam logic [UVDC_CP_W-1:0] UVDC_CP_MAX  = 21'h10FFFF;

endpackage

// ===== rtl/uvdc_if.sv =====
// Stream interfaces: raw bytes in, decoded results out.
interface uvdc_in_if import uvdc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface uvdc_out_if import uvdc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [UVDC_CP_W-1:0]  scalar_value;
    logic                  point_ready;
    logic                  string_done;
    logic                  string_ok;
    logic [UVDC_CNT_W-1:0] point_total;
    logic [UVDC_CNT_W-1:0] byte_count;

    modport source (
        output valid, output scalar_value, output point_ready, output string_done,
        output string_ok, output point_total, output byte_count, input ready
    );
    modport sink (
        input valid, input scalar_value, input point_ready, input string_done,
        input string_ok, input point_total, input byte_count, output ready
    );
endinterface

// ===== rtl/utf8_validate_decode_count_top.sv =====
// Top level of the streaming strict UTF-8 validator, decoder and counter.
// Path: a byte passes through one input register and then one result register before
//   its result shows at the output.
// Throughput: one byte per clock unless stalled; the input register frees whenever the
//   result register moves on, so a byte can be taken while a finished result waits.
// Reset: synchronous, active low; clears both valid flags and all per-string decode state.
module utf8_validate_decode_count_top import uvdc_pkg::*; #(
    parameter int COUNT_BITS = UVDC_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uvdc_in_if.sink     i_str,
    uvdc_out_if.source  o_res
);

    localparam logic [COUNT_BITS-1:0] TallyOne = COUNT_BITS'(1);

    // Input register: holds one byte until the decoder can pass its result on
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Per-string decode state
    logic [UVDC_PEND_W-1:0] r_pending,   n_pending;
    logic [UVDC_LEN_W-1:0]  r_seq_len,   n_seq_len;
    logic [UVDC_CP_W-1:0]   r_partial,   n_partial;
    logic                   r_err,       n_err;
    logic [COUNT_BITS-1:0]  r_pt_tally,  n_pt_tally;
    logic [COUNT_BITS-1:0]  r_by_tally,  n_by_tally;

    // Result register
    logic                  r_out_valid;
    logic [UVDC_CP_W-1:0]  r_cp,       n_cp;
    logic                  r_ready_pt, n_ready_pt;
    logic                  r_done;
    logic                  r_ok,       n_ok;
    logic [UVDC_CNT_W-1:0] r_char_cnt;
    logic [UVDC_CNT_W-1:0] r_byte_cnt;

    logic                 w_adv;
    logic [UVDC_CP_W-1:0] w_value;
    logic                 w_bad;
    logic [COUNT_BITS-1:0] w_by_inc;
    logic [COUNT_BITS-1:0] w_pt_inc;

    // The held byte moves on when the result register is empty or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_str.ready = !r_in_valid || w_adv;

    // Saturating increments: stop at all ones
    assign w_by_inc = (&r_by_tally) ? r_by_tally : r_by_tally + TallyOne;

    // Value after appending this continuation byte's six bits
    assign w_value = {r_partial[UVDC_CP_W-7:0], r_in_byte[5:0]};

    // Strict checks on a completed multi-byte sequence
    always_comb begin
        w_bad = 1'b0;
        if (r_seq_len == UVDC_LEN_3 && w_value < UVDC_MIN_3) begin
            w_bad = 1'b1;
        end
        if (r_seq_len == UVDC_LEN_4 && w_value < UVDC_MIN_4) begin
            w_bad = 1'b1;
        end
        if (w_value inside {[UVDC_SURR_LO:UVDC_SURR_HI]}) begin
            w_bad = 1'b1;
        end
        if (w_value > UVDC_CP_MAX) begin
            w_bad = 1'b1;
        end
    end

    // Decode one byte against the open sequence
    always_comb begin
        n_pending  = r_pending;
        n_seq_len  = r_seq_len;
        n_partial  = r_partial;
        n_err      = r_err;
        n_cp       = '0;
        n_ready_pt = 1'b0;

        if (!r_err) begin
            if (r_pending == '0) begin
                if (!r_in_byte[7]) begin
                    // Plain ASCII completes at once
                    n_cp       = UVDC_CP_W'(r_in_byte);
                    n_ready_pt = 1'b1;
                end else if (r_in_byte inside {[UVDC_B2_LO:UVDC_B2_HI]}) begin
                    n_seq_len = UVDC_LEN_2;
                    n_pending = 2'd1;
                    n_partial = UVDC_CP_W'(r_in_byte[4:0]);
                end else if (r_in_byte inside {[UVDC_B3_LO:UVDC_B3_HI]}) begin
                    n_seq_len = UVDC_LEN_3;
                    n_pending = 2'd2;
                    n_partial = UVDC_CP_W'(r_in_byte[3:0]);
                end else if (r_in_byte inside {[UVDC_B4_LO:UVDC_B4_HI]}) begin
                    n_seq_len = UVDC_LEN_4;
                    n_pending = 2'd3;
                    n_partial = UVDC_CP_W'(r_in_byte[2:0]);
                end else begin
                    // Stray continuation, overlong two-byte lead or lead above F4
                    n_err = 1'b1;
                end
            end else if (r_in_byte[7:6] != 2'b10) begin
                n_err = 1'b1;
            end else begin
                n_partial = w_value;
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    if (w_bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_cp       = w_value;
                        n_ready_pt = 1'b1;
                    end
                    n_partial = '0;
                    n_seq_len = UVDC_LEN_NONE;
                end
            end
        end

        w_pt_inc   = (&r_pt_tally) ? r_pt_tally : r_pt_tally + TallyOne;
        n_pt_tally = n_ready_pt ? w_pt_inc : r_pt_tally;
        n_by_tally = w_by_inc;
        n_ok       = r_in_last && !n_err && (n_pending == '0);
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_str.valid && i_str.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (i_str.valid && i_str.ready) begin
            r_in_byte <= i_str.data_byte;
            r_in_last <= i_str.last_byte;
        end
    end

    // Decode state: advance per byte, clear after the last byte of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_seq_len  <= UVDC_LEN_NONE;
            r_partial  <= '0;
            r_err      <= 1'b0;
            r_pt_tally <= '0;
            r_by_tally <= '0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_pending  <= '0;
                r_seq_len  <= UVDC_LEN_NONE;
                r_partial  <= '0;
                r_err      <= 1'b0;
                r_pt_tally <= '0;
                r_by_tally <= '0;
            end else begin
                r_pending  <= n_pending;
                r_seq_len  <= n_seq_len;
                r_partial  <= n_partial;
                r_err      <= n_err;
                r_pt_tally <= n_pt_tally;
                r_by_tally <= n_by_tally;
            end
        end
    end

    // Result register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv) begin
            r_cp       <= n_cp;
            r_ready_pt <= n_ready_pt;
            r_done     <= r_in_last;
            r_ok       <= n_ok;
            // Tallies show masked or widened to the port width
            r_char_cnt <= UVDC_CNT_W'(n_pt_tally);
            r_byte_cnt <= UVDC_CNT_W'(n_by_tally);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.scalar_value = r_cp;
    assign o_res.point_ready  = r_ready_pt;
    assign o_res.string_done  = r_done;
    assign o_res.string_ok    = r_ok;
    assign o_res.point_total  = r_char_cnt;
    assign o_res.byte_count   = r_byte_cnt;

endmodule

// ===== rtl/uvdc_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
module uvdc_checker import uvdc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  i_ready,
    input logic [UVDC_CP_W-1:0]  i_scalar_value,
    input logic                  i_point_ready,
    input logic                  i_string_done,
    input logic                  i_string_ok,
    input logic [UVDC_CNT_W-1:0] i_point_total,
    input logic [UVDC_CNT_W-1:0] i_byte_count
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_scalar_value) && $stable(i_point_ready)
            && $stable(i_string_done) && $stable(i_string_ok)
            && $stable(i_point_total) && $stable(i_byte_count))
        else $error("result changed while stalled");

    // Only legal scalar values are emitted
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_point_ready |-> i_scalar_value <= UVDC_CP_MAX
            && (i_scalar_value < UVDC_SURR_LO || i_scalar_value > UVDC_SURR_HI))
        else $error("illegal code point emitted");

    // No value leaks out without a completed point
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_point_ready |-> i_scalar_value == '0)
        else $error("code point set without completion");

    // A verdict appears only on the last byte
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_string_ok |-> i_string_done)
        else $error("string_ok outside string end");

    // Every result counts its own byte
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_byte_count != '0)
        else $error("byte count zero on a result");

endmodule

bind utf8_validate_decode_count_top uvdc_checker u_uvdc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_res.valid),
    .i_ready        (o_res.ready),
    .i_scalar_value (o_res.scalar_value),
    .i_point_ready  (o_res.point_ready),
    .i_string_done  (o_res.string_done),
    .i_string_ok    (o_res.string_ok),
    .i_point_total  (o_res.point_total),
    .i_byte_count   (o_res.byte_count)
);

// ===== tb/tb_utf8_validate_decode_count_top.sv =====
// Self-checking testbench for the streaming strict UTF-8 validator, decoder and counter.
`timescale 1ns / 1ps

module tb_utf8_validate_decode_count_top;
    import uvdc_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;     // idle cycles the source holds after this transfer
    } t_text_byte;

    typedef struct {
        logic [UVDC_CP_W-1:0]  scalar_value;
        logic                  point_ready;
        logic                  string_done;
        logic                  string_ok;
        logic [UVDC_CNT_W-1:0] point_total;
        logic [UVDC_CNT_W-1:0] byte_count;
    } t_utf8_result;

    logic i_clk;
    logic i_rst_n;

    uvdc_in_if  str_if ();
    uvdc_out_if res_if ();

    utf8_validate_decode_count_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_str   (str_if),
        .o_res   (res_if)
    );

    // Stimulus bytes waiting for the source, and decoder results still owed by the block
    t_text_byte   pending[$];
    t_utf8_result due_results[$];
    logic [7:0]   draft[$];        // scratch buffer for building one string

    int unsigned mismatches = 0;
    int unsigned src_hold = 0;
    int unsigned sink_hold = 0;
    int unsigned calm_left = 0;
    t_text_byte   next_byte;
    t_utf8_result want;

    // Decoder state, mirrored from the block's behaviour; zero is the reset state
    logic [UVDC_PEND_W-1:0]     owed       = '0;
    logic [UVDC_LEN_W-1:0]      seq_len    = UVDC_LEN_NONE;
    logic [UVDC_CP_W-1:0]       gathered   = '0;
    logic                       broken     = 1'b0;
    logic [UVDC_COUNT_BITS-1:0] char_tally = '0;
    logic [UVDC_COUNT_BITS-1:0] byte_tally = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [UVDC_COUNT_BITS-1:0] bump(input logic [UVDC_COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the decoder by one byte and return the result the block must give for it
    function automatic t_utf8_result decode_byte(input logic [7:0] b, input logic fin);
        t_utf8_result r;
        logic         bad;
        r = '{default: '0};
        byte_tally = bump(byte_tally);
        if (!broken) begin
            if (owed == 0) begin
                if (b < 8'h80) begin
                    r.scalar_value = UVDC_CP_W'(b);
                    r.point_ready  = 1'b1;
                end else if (b >= UVDC_B2_LO && b <= UVDC_B2_HI) begin
                    seq_len  = UVDC_LEN_2;
                    owed     = 2'd1;
                    gathered = UVDC_CP_W'(b[4:0]);
                end else if (b >= UVDC_B3_LO && b <= UVDC_B3_HI) begin
                    seq_len  = UVDC_LEN_3;
                    owed     = 2'd2;
                    gathered = UVDC_CP_W'(b[3:0]);
                end else if (b >= UVDC_B4_LO && b <= UVDC_B4_HI) begin
                    seq_len  = UVDC_LEN_4;
                    owed     = 2'd3;
                    gathered = UVDC_CP_W'(b[2:0]);
                end else begin
                    broken = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                broken = 1'b1;
            end else begin
                gathered = {gathered[UVDC_CP_W-7:0], b[5:0]};
                owed     = owed - 1'b1;
                if (owed == 0) begin
                    // overlong forms, surrogates and anything past the top of Unicode
                    bad = (seq_len == UVDC_LEN_3 && gathered < UVDC_MIN_3)
                       || (seq_len == UVDC_LEN_4 && gathered < UVDC_MIN_4)
                       || (gathered >= UVDC_SURR_LO && gathered <= UVDC_SURR_HI)
                       || (gathered > UVDC_CP_MAX);
                    if (bad) begin
                        broken = 1'b1;
                    end else begin
                        r.scalar_value = gathered;
                        r.point_ready  = 1'b1;
                    end
                    gathered = '0;
                    seq_len  = UVDC_LEN_NONE;
                end
            end
            if (r.point_ready)
                char_tally = bump(char_tally);
        end
        r.string_done = fin;
        r.string_ok   = fin && !broken && owed == 0;
        r.point_total = UVDC_CNT_W'(char_tally);
        r.byte_count  = UVDC_CNT_W'(byte_tally);
        if (fin) begin
            owed       = '0;
            seq_len    = UVDC_LEN_NONE;
            gathered   = '0;
            broken     = 1'b0;
            char_tally = '0;
            byte_tally = '0;
        end
        return r;
    endfunction

    // Append the shortest UTF-8 form of a value (also used for illegal values)
    function automatic void emit_point(input logic [UVDC_CP_W-1:0] cp);
        if (cp < 21'h80) begin
            draft.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            draft.push_back({3'b110, cp[10:6]});
            draft.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            draft.push_back({4'b1110, cp[15:12]});
            draft.push_back({2'b10, cp[11:6]});
            draft.push_back({2'b10, cp[5:0]});
        end else begin
            draft.push_back({5'b11110, cp[20:18]});
            draft.push_back({2'b10, cp[17:12]});
            draft.push_back({2'b10, cp[11:6]});
            draft.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void emit_valid_char();
        logic [UVDC_CP_W-1:0] cp;
        case ($urandom_range(0, 3))
            0: cp = UVDC_CP_W'($urandom_range(0, 'h7F));
            1: cp = UVDC_CP_W'($urandom_range('h80, 'h7FF));
            2: begin
                cp = UVDC_CP_W'($urandom_range('h800, 'hFFFF));
                // step out of the surrogate block
                if (cp >= UVDC_SURR_LO && cp <= UVDC_SURR_HI)
                    cp = cp ^ 21'h2000;
            end
            default: cp = UVDC_CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        emit_point(cp);
    endfunction

    // Append one fault of the given kind (kind 0: any byte; truncation is the caller's)
    function automatic void emit_fault(input int unsigned kind);
        logic [UVDC_CP_W-1:0] v;
        logic [7:0]           b;
        case (kind)
            0: draft.push_back(8'($urandom_range(0, 255)));
            1: draft.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                                    : 8'($urandom_range('hF5, 'hFF)));
            2: begin
                // start byte of a longer sequence followed by a non-continuation byte
                draft.push_back(8'($urandom_range('hC2, 'hF4)));
                b = 8'($urandom_range(0, 191));
                if (b >= 8'h80)
                    b = b + 8'h40;
                draft.push_back(b);
            end
            3: begin
                if ($urandom_range(0, 1)) begin
                    v = UVDC_CP_W'($urandom_range(0, 'h7FF));
                    draft.push_back(8'hE0);
                    draft.push_back({2'b10, v[11:6]});
                    draft.push_back({2'b10, v[5:0]});
                end else begin
                    v = UVDC_CP_W'($urandom_range(0, 'hFFFF));
                    draft.push_back(8'hF0);
                    draft.push_back({2'b10, v[17:12]});
                    draft.push_back({2'b10, v[11:6]});
                    draft.push_back({2'b10, v[5:0]});
                end
            end
            4: emit_point(21'($urandom_range('hD800, 'hDFFF)));
            default: emit_point(21'($urandom_range('h110000, 'h1FFFFF)));
        endcase
    endfunction

    // Move the draft into the source queue, marking its final byte; returns its length
    function automatic int unsigned queue_string(input bit steady);
        t_text_byte t;
        int unsigned n;
        n = draft.size();
        foreach (draft[i]) begin
            t.data = draft[i];
            t.last = (i == n - 1);
            t.gap  = steady ? 0 : $urandom_range(0, 8);
            pending.push_back(t);
        end
        draft.delete();
        return n;
    endfunction

    task automatic drain();
        while (pending.size() != 0 || str_if.valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Source: hold each byte until it transfers, then idle for its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            str_if.valid <= 1'b0;
            src_hold     = 0;
        end else if (!str_if.valid || str_if.ready) begin
            if (src_hold != 0) begin
                str_if.valid <= 1'b0;
                src_hold     = src_hold - 1;
            end else if (pending.size() != 0) begin
                next_byte = pending.pop_front();
                str_if.valid     <= 1'b1;
                str_if.data_byte <= next_byte.data;
                str_if.last_byte <= next_byte.last;
                src_hold         = next_byte.gap;
            end else begin
                str_if.valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted byte; the result cannot come back in the same cycle
    always @(posedge i_clk) begin
        if (i_rst_n && str_if.valid && str_if.ready)
            due_results.push_back(decode_byte(str_if.data_byte, str_if.last_byte));
    end

    // Sink: check each transfer against the oldest prediction, then stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_hold    = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no byte outstanding");
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("scalar_value", 32'(want.scalar_value),
                                32'(res_if.scalar_value));
                    check_field("point_ready", 32'(want.point_ready),
                                32'(res_if.point_ready));
                    check_field("string_done", 32'(want.string_done),
                                32'(res_if.string_done));
                    check_field("string_ok", 32'(want.string_ok), 32'(res_if.string_ok));
                    check_field("point_total", 32'(want.point_total),
                                32'(res_if.point_total));
                    check_field("byte_count", 32'(want.byte_count), 32'(res_if.byte_count));
                end
                if (calm_left != 0) begin
                    sink_hold = 0;
                    calm_left--;
                end else begin
                    // now and then open a stretch with no back-pressure
                    if ($urandom_range(0, 24) == 0)
                        calm_left = $urandom_range(10, 40);
                    sink_hold = $urandom_range(0, 8);
                end
            end else if (sink_hold != 0) begin
                sink_hold--;
            end
            res_if.ready <= (sink_hold == 0);
        end
    end

    initial begin
        int unsigned sent;
        int unsigned nchar;
        int unsigned fault;
        int unsigned fault_at;
        int unsigned cut;
        bit          faulty;
        bit          steady;

        i_rst_n          = 1'b0;
        str_if.valid     = 1'b0;
        str_if.data_byte = 8'h00;
        str_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: boundaries of every sequence length in one valid string
        draft = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
                  8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF};
        void'(queue_string(1'b0));
        // lone illegal start byte as a single-byte string
        draft = '{8'hC1};
        void'(queue_string(1'b0));
        // error, then a byte that must be ignored
        draft = '{8'hFF, 8'h41};
        void'(queue_string(1'b0));
        // sequence left open on the final byte
        draft = '{8'hE2, 8'h82};
        void'(queue_string(1'b0));
        drain();

        // Random: mostly well-formed strings, some with one fault, some raw noise
        sent = 0;
        while (sent < 500) begin
            steady = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) draft.push_back(8'($urandom_range(0, 255)));
            end else begin
                nchar    = $urandom_range(1, 10);
                faulty   = ($urandom_range(0, 3) == 0);
                fault    = $urandom_range(0, 6);
                fault_at = $urandom_range(0, nchar - 1);
                for (int i = 0; i < nchar; i++) begin
                    if (faulty && fault != 6 && i == fault_at)
                        emit_fault(fault);
                    emit_valid_char();
                end
                if (faulty && fault == 6) begin
                    // cut a multi-byte sequence short at the end of the string
                    emit_point(21'($urandom_range('h80, 'hD7FF)));
                    cut = (draft[draft.size() - 2][7:6] == 2'b10) ? $urandom_range(1, 2) : 1;
                    repeat (cut) void'(draft.pop_back());
                end
            end
            sent += queue_string(steady);
        end
        drain();

        // the block holds at most two bytes in flight
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== utf8_validate_decode_count_top.f =====
rtl/uvdc_pkg.sv
rtl/uvdc_if.sv
rtl/utf8_validate_decode_count_top.sv
rtl/uvdc_checker.sv
tb/tb_utf8_validate_decode_count_top.sv
